@@ sv/clf_pkg.sv @@
// shared types, character constants and prefix tables of the command line framer
package clf_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int CHAR_INDEX_W   = 6;

    localparam logic [7:0] CHAR_AT       = 8'h40;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'h7E;

    // line kind codes, also used as the prefix class held during a line
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_LOG  = 3'd2,
        KIND_P63  = 3'd3,
        KIND_ENG  = 3'd4,
        KIND_REG  = 3'd5,
        KIND_OTA  = 3'd6,
        KIND_WIFI = 3'd7
    } line_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LINE = 2'd1,
        ST_READ = 2'd2,
        ST_LOAD = 2'd3
    } clf_state_t;

    typedef struct packed {
        logic open_cmd;
        logic open_log;
        logic store_char;
        logic start_replay;
        logic load_out;
        logic advance;
    } clf_cmd_t;

    typedef struct packed {
        logic is_at;
        logic is_bracket;
        logic is_term;
        logic is_print;
        logic room;
        logic gate_ok;
        logic empty;
        logic out_free;
        logic last_char;
    } clf_status_t;

    function automatic logic [2:0] prefix_len(line_kind_t k);
        logic [2:0] n;
        case (k)
            KIND_LOG:  n = 3'd5;
            KIND_WIFI: n = 3'd5;
            KIND_NONE: n = 3'd0;
            default:   n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] prefix_char(line_kind_t k, logic [2:0] pos);
        logic [39:0] w;
        logic [7:0]  c;
        case (k)
            KIND_SUB:  w = 40'h5355427C00;
            KIND_LOG:  w = 40'h5B5355425D;
            KIND_P63:  w = 40'h5036337C00;
            KIND_ENG:  w = 40'h454E477C00;
            KIND_REG:  w = 40'h5245477C00;
            KIND_OTA:  w = 40'h4F54417C00;
            KIND_WIFI: w = 40'h574946497C;
            default:   w = 40'h0;
        endcase
        case (pos)
            3'd0:    c = w[39:32];
            3'd1:    c = w[31:24];
            3'd2:    c = w[23:16];
            3'd3:    c = w[15:8];
            3'd4:    c = w[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // class picked by the first character of a command line
    function automatic line_kind_t first_kind(logic [7:0] ch);
        line_kind_t k;
        case (ch)
            8'h53:   k = KIND_SUB;
            8'h50:   k = KIND_P63;
            8'h57:   k = KIND_WIFI;
            8'h45:   k = KIND_ENG;
            8'h52:   k = KIND_REG;
            8'h4F:   k = KIND_OTA;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ sv/clf_in_if.sv @@
// received byte channel
interface clf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/clf_out_if.sv @@
// line character channel
interface clf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] line_char;
    logic [5:0] char_index;
    logic [2:0] line_kind;
    logic       last_of_line;

    modport source (output valid, output line_char, output char_index, output line_kind,
                    output last_of_line, input ready);
    modport sink   (input valid, input line_char, input char_index, input line_kind,
                    input last_of_line, output ready);
endinterface

@@ sv/command_line_framer_prefix_gate.sv @@
// the CR/LF beat of a line starts replay: the line store is read, then the output loaded
// throughput: one received beat per cycle while a line is collected
// replay reads each character of the line from the line store, then loads the output;
// no received beat is taken during replay, and a stalled sink holds off the output load
// reset: asynchronous, active low; clears the controller, length, class, read index
// and output valid; the line store is left as it is and is written before it is read
module command_line_framer_prefix_gate #(
    parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    clf_in_if.sink    uart,
    clf_out_if.source chars
);

    clf_pkg::clf_cmd_t    cmd;
    clf_pkg::clf_status_t stat;

    clf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (uart.valid),
        .in_ready (uart.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clf_dpath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (uart.rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (chars.valid),
        .out_ready    (chars.ready),
        .line_char    (chars.line_char),
        .char_index   (chars.char_index),
        .line_kind    (chars.line_kind),
        .last_of_line (chars.last_of_line)
    );

endmodule

@@ sv/clf_ctrl.sv @@
// controller state machine of the command line framer
module clf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  clf_pkg::clf_status_t stat,
    output clf_pkg::clf_cmd_t    cmd
);

    clf_pkg::clf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            clf_pkg::ST_IDLE:
            begin
                if (in_valid && (stat.is_at || stat.is_bracket))
                begin
                    state_next = clf_pkg::ST_LINE;
                end
            end
            clf_pkg::ST_LINE:
            begin
                if (in_valid)
                begin
                    if (stat.is_term)
                    begin
                        state_next = stat.empty ? clf_pkg::ST_IDLE : clf_pkg::ST_READ;
                    end
                    else if (!stat.is_print || !stat.room || !stat.gate_ok)
                    begin
                        state_next = clf_pkg::ST_IDLE;
                    end
                end
            end
            clf_pkg::ST_READ:
            begin
                state_next = clf_pkg::ST_LOAD;
            end
            clf_pkg::ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_char ? clf_pkg::ST_IDLE : clf_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = clf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            clf_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.open_cmd = in_valid && stat.is_at;
                cmd.open_log = in_valid && stat.is_bracket;
            end
            clf_pkg::ST_LINE:
            begin
                in_ready         = 1'b1;
                cmd.start_replay = in_valid && stat.is_term && !stat.empty;
                cmd.store_char   = in_valid && !stat.is_term && stat.is_print && stat.room;
            end
            clf_pkg::ST_READ:
            begin
                in_ready = 1'b0;
            end
            clf_pkg::ST_LOAD:
            begin
                cmd.load_out = stat.out_free;
                cmd.advance  = stat.out_free && !stat.last_char;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/clf_dpath.sv @@
// datapath: line store, length, prefix gate and output register
module clf_dpath #(
    parameter int LINE_BYTES = clf_pkg::LINE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  clf_pkg::clf_cmd_t    cmd,
    output clf_pkg::clf_status_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           line_char,
    output logic [5:0]           char_index,
    output logic [2:0]           line_kind,
    output logic                 last_of_line
);

    localparam int AW = $clog2(LINE_BYTES);

    logic [6:0] store_mem [LINE_BYTES];
    logic [6:0] rdata_reg;

    logic [AW-1:0]       length_reg, length_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    clf_pkg::line_kind_t cls_reg, cls_next;
    logic                out_valid_reg, out_valid_next;

    logic [6:0]          out_char_reg;
    logic [AW-1:0]       out_idx_reg;
    clf_pkg::line_kind_t out_kind_reg;
    logic                out_last_reg;

    logic [AW-1:0]       wr_addr;
    logic [6:0]          wr_data;
    logic                wr_en;
    logic [2:0]          plen;
    logic                in_prefix;
    logic [7:0]          want;
    clf_pkg::line_kind_t kind_now;

    // prefix gate: first character picks the class, later prefix positions must match
    always_comb
    begin
        plen      = clf_pkg::prefix_len(cls_reg);
        in_prefix = length_reg < AW'(plen);
        want      = clf_pkg::prefix_char(cls_reg, length_reg[2:0]);
        kind_now  = (length_reg >= AW'(plen)) ? cls_reg : clf_pkg::KIND_NONE;
    end

    always_comb
    begin
        stat.is_at      = rx_byte == clf_pkg::CHAR_AT;
        stat.is_bracket = rx_byte == clf_pkg::CHAR_LBRACKET;
        stat.is_term    = (rx_byte == clf_pkg::CHAR_CR) || (rx_byte == clf_pkg::CHAR_LF);
        stat.is_print   = (rx_byte >= clf_pkg::PRINT_LO) && (rx_byte <= clf_pkg::PRINT_HI);
        stat.room       = ({1'b0, length_reg} + (AW+1)'(1)) < (AW+1)'(LINE_BYTES);
        if (length_reg == '0)
        begin
            stat.gate_ok = clf_pkg::first_kind(rx_byte) != clf_pkg::KIND_NONE;
        end
        else
        begin
            stat.gate_ok = !in_prefix || (rx_byte == want);
        end
        stat.empty      = length_reg == '0;
        stat.out_free   = !out_valid_reg || out_ready;
        stat.last_char  = rd_idx_reg == (length_reg - AW'(1));
    end

    always_comb
    begin
        length_next = length_reg;
        cls_next    = cls_reg;
        rd_idx_next = rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = length_reg;
        wr_data     = rx_byte[6:0];
        if (cmd.open_cmd)
        begin
            length_next = '0;
            cls_next    = clf_pkg::KIND_NONE;
        end
        if (cmd.open_log)
        begin
            length_next = AW'(1);
            cls_next    = clf_pkg::KIND_LOG;
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_data     = clf_pkg::CHAR_LBRACKET[6:0];
        end
        if (cmd.store_char)
        begin
            length_next = length_reg + AW'(1);
            wr_en       = 1'b1;
            if (length_reg == '0)
            begin
                cls_next = clf_pkg::first_kind(rx_byte);
            end
        end
        if (cmd.start_replay)
        begin
            rd_idx_next = '0;
        end
        if (cmd.advance)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            cls_reg       <= clf_pkg::KIND_NONE;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            cls_reg       <= cls_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= store_mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_char_reg <= rdata_reg;
            out_idx_reg  <= rd_idx_reg;
            out_kind_reg <= kind_now;
            out_last_reg <= stat.last_char;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_char    = out_char_reg;
    assign char_index   = clf_pkg::CHAR_INDEX_W'(out_idx_reg);
    assign line_kind    = out_kind_reg;
    assign last_of_line = out_last_reg;

endmodule
